### src/gnpc_pkg.sv
`default_nettype none
package gnpc_pkg;

  localparam int CNT_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_FETCH_MID,
    ST_FETCH_DN,
    ST_SCAN,
    ST_ROW_END,
    ST_ROUND_END,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_write;    // store the accepted cell and advance the load position
    logic clear_step;    // write the pending row buffer and advance to the next row
    logic scan_start;    // start a round at the top left cell and fetch the top row
    logic fetch_mid;     // take the fetched top row as the current row
    logic fetch_dn;      // take the fetched row below the current one
    logic scan_step;     // evaluate one cell and advance the scan position
    logic row_end;       // write back the current row and move the window down
    logic round_close;   // fold the round count into the totals
    logic finish;        // result taken: zero the load position and totals
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;    // every row of the grid has been written
    logic row_last;      // the cell under evaluation is the last of its row
    logic grid_last_row; // the current row is the last of the grid
    logic round_hit;     // the round just closed removed at least one cell
  } dp_stat_t;

endpackage
`default_nettype wire

### src/gnpc_ctrl.sv
`default_nettype none
module gnpc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              last_cell,
  input  wire logic              out_ready,
  input  wire gnpc_pkg::dp_stat_t stat,
  output gnpc_pkg::dp_cmd_t      cmd,
  output logic                   in_ready,
  output logic                   out_valid
);
  import gnpc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_fire && last_cell) state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (stat.clear_done) state_next = ST_FETCH_MID;
      end
      ST_FETCH_MID: begin
        state_next = ST_FETCH_DN;
      end
      ST_FETCH_DN: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.row_last) state_next = ST_ROW_END;
      end
      ST_ROW_END: begin
        if (stat.grid_last_row) state_next = ST_ROUND_END;
        else state_next = ST_FETCH_DN;
      end
      ST_ROUND_END: begin
        if (stat.round_hit) state_next = ST_FETCH_MID;
        else state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_ready) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load_write = in_fire;
      end
      ST_CLEAR: begin
        cmd.clear_step = !stat.clear_done;
        cmd.scan_start = stat.clear_done;
      end
      ST_FETCH_MID: begin
        cmd.fetch_mid = 1'b1;
      end
      ST_FETCH_DN: begin
        cmd.fetch_dn = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_ROW_END: begin
        cmd.row_end = 1'b1;
      end
      ST_ROUND_END: begin
        cmd.round_close = 1'b1;
        cmd.scan_start = stat.round_hit;
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        cmd.finish = out_ready;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/gnpc_datapath.sv
`default_nettype none
module gnpc_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gnpc_pkg::dp_cmd_t  cmd,
  input  wire logic               cell_occupied,
  input  wire logic [8:0]         grid_width,
  input  wire logic [8:0]         grid_height,
  input  wire logic [3:0]         neighbor_limit,
  output gnpc_pkg::dp_stat_t      stat,
  output logic [gnpc_pkg::CNT_W-1:0] total_removed,
  output logic [gnpc_pkg::CNT_W-1:0] first_round_removed,
  output logic [gnpc_pkg::CNT_W-1:0] round_count
);
  import gnpc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int XCW = $clog2(MAX_WIDTH + 1);
  localparam int YCW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (XCW > 9) ? XCW : 9;
  localparam int RW = (YCW > 9) ? YCW : 9;

  // Effective sizes: zero acts as one, oversize saturates.
  logic [XCW-1:0] w_eff;
  logic [YCW-1:0] h_eff;
  always_comb begin
    if (grid_width == 9'd0) w_eff = XCW'(1);
    else if (CW'(grid_width) > CW'(MAX_WIDTH)) w_eff = XCW'(MAX_WIDTH);
    else w_eff = XCW'(grid_width);
    if (grid_height == 9'd0) h_eff = YCW'(1);
    else if (RW'(grid_height) > RW'(MAX_HEIGHT)) h_eff = YCW'(MAX_HEIGHT);
    else h_eff = YCW'(grid_height);
  end

  // One grid row per memory word, one write and one registered read a cycle.
  logic [MAX_WIDTH-1:0] grid [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_data;
  logic                 mem_we;
  logic [YW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [YW-1:0]        mem_raddr;

  logic [XCW-1:0] load_column;
  logic [YCW-1:0] load_row;
  logic [MAX_WIDTH-1:0] load_buf;
  logic [MAX_WIDTH-1:0] buf_set;
  logic load_wrap;
  logic [XCW-1:0] px;
  logic [YCW-1:0] py;
  logic [CNT_W-1:0] round_removed;
  logic [CNT_W-1:0] removed_sum;
  logic [CNT_W-1:0] first_round_sum;
  logic [CNT_W-1:0] rounds_done;

  // Row window: above (already peeled this round), current and below.
  logic [MAX_WIDTH-1:0] r_up;
  logic [MAX_WIDTH-1:0] r_mid;
  logic [MAX_WIDTH-1:0] r_dn;

  // A row is assembled in a buffer during the load and written once complete.
  always_comb begin
    buf_set = load_buf;
    if ((load_row < h_eff) && (load_column < w_eff)) begin
      buf_set[load_column[XW-1:0]] = cell_occupied;
    end
    load_wrap = (load_row < h_eff) && ((load_column + XCW'(1)) >= w_eff);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = load_row[YW-1:0];
    mem_wdata = load_buf;
    if (cmd.load_write && load_wrap) begin
      mem_we = 1'b1;
      mem_wdata = buf_set;
    end else if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.row_end) begin
      mem_we = 1'b1;
      mem_waddr = py[YW-1:0];
      mem_wdata = r_mid;
    end
  end

  // The row two below is fetched while the window moves down.
  always_comb begin
    if (cmd.scan_start) mem_raddr = '0;
    else if (cmd.row_end) mem_raddr = YW'(py + YCW'(2));
    else mem_raddr = YW'(py + YCW'(1));
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_waddr] <= mem_wdata;
    rd_data <= grid[mem_raddr];
  end

  logic [XW-1:0] px_i;
  logic [XW-1:0] px_l;
  logic [XW-1:0] px_r;
  logic has_l;
  logic has_r;
  logic [3:0] nb;
  logic self_occ;
  logic remove;
  always_comb begin
    px_i = px[XW-1:0];
    px_l = XW'(px - XCW'(1));
    px_r = XW'(px + XCW'(1));
    has_l = (px != '0);
    has_r = ((px + XCW'(1)) < w_eff);
    nb = 4'd0;
    if (has_l) nb = nb + 4'(r_up[px_l]) + 4'(r_mid[px_l]) + 4'(r_dn[px_l]);
    nb = nb + 4'(r_up[px_i]) + 4'(r_dn[px_i]);
    if (has_r) nb = nb + 4'(r_up[px_r]) + 4'(r_mid[px_r]) + 4'(r_dn[px_r]);
    self_occ = r_mid[px_i];
    remove = self_occ && (nb < neighbor_limit);
  end

  always_comb begin
    stat.clear_done = (load_row >= h_eff);
    stat.row_last = ((px + XCW'(1)) >= w_eff);
    stat.grid_last_row = ((py + YCW'(1)) >= h_eff);
    stat.round_hit = (round_removed != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_column <= '0;
      load_row <= '0;
      load_buf <= '0;
      px <= '0;
      py <= '0;
      r_up <= '0;
      r_mid <= '0;
      r_dn <= '0;
      round_removed <= '0;
      removed_sum <= '0;
      first_round_sum <= '0;
      rounds_done <= '0;
    end else begin
      if (cmd.load_write && (load_row < h_eff)) begin
        if (load_wrap) begin
          load_column <= '0;
          load_row <= load_row + YCW'(1);
          load_buf <= '0;
        end else begin
          load_column <= load_column + XCW'(1);
          load_buf <= buf_set;
        end
      end
      // The partly loaded row goes out first, every later row is written empty.
      if (cmd.clear_step) begin
        load_buf <= '0;
        load_row <= load_row + YCW'(1);
      end
      if (cmd.scan_start) begin
        px <= '0;
        py <= '0;
        r_up <= '0;
        round_removed <= '0;
      end
      if (cmd.fetch_mid) r_mid <= rd_data;
      if (cmd.fetch_dn) r_dn <= ((py + YCW'(1)) < h_eff) ? rd_data : '0;
      if (cmd.scan_step) begin
        if (remove) begin
          r_mid[px_i] <= 1'b0;
          round_removed <= round_removed + CNT_W'(1);
        end
        if ((px + XCW'(1)) >= w_eff) px <= '0;
        else px <= px + XCW'(1);
      end
      if (cmd.row_end) begin
        r_up <= r_mid;
        r_mid <= r_dn;
        py <= py + YCW'(1);
      end
      if (cmd.round_close && (round_removed != '0)) begin
        if (rounds_done == '0) first_round_sum <= round_removed;
        rounds_done <= rounds_done + CNT_W'(1);
        removed_sum <= removed_sum + round_removed;
      end
      if (cmd.finish) begin
        load_column <= '0;
        load_row <= '0;
        load_buf <= '0;
        round_removed <= '0;
        removed_sum <= '0;
        first_round_sum <= '0;
        rounds_done <= '0;
      end
    end
  end

  assign total_removed = removed_sum;
  assign first_round_removed = first_round_sum;
  assign round_count = rounds_done;

endmodule
`default_nettype wire

### src/grid_neighbor_peeling_counter.sv
// Load: one cell request per cycle, one grid at a time.
// After the last cell, every row not yet completed is written, then the first round starts.
// Each peeling round scans the grid row by row, cell by cell; rounds repeat until one removes
// nothing, and the result then waits for out_ready before the next load is taken.
// Reset (synchronous, active high) clears the load position and totals and sets the
// registers to 256 by 256 with limit 4; grid rows are always written before use.
`default_nettype none
module grid_neighbor_peeling_counter #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cell_occupied,
  input  wire logic        last_cell,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      total_removed,
  output logic [16:0]      first_round_removed,
  output logic [16:0]      round_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [gnpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gnpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gnpc_pkg::*;

  logic [8:0] grid_width;
  logic [8:0] grid_height;
  logic [3:0] neighbor_limit;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 9'd256;
      grid_height <= 9'd256;
      neighbor_limit <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRID_WIDTH:     grid_width <= cfg_data;
        REG_GRID_HEIGHT:    grid_height <= cfg_data;
        REG_NEIGHBOR_LIMIT: neighbor_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  gnpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .last_cell(last_cell),
    .out_ready(out_ready), .stat(stat), .cmd(cmd),
    .in_ready(in_ready), .out_valid(out_valid)
  );

  gnpc_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .cell_occupied(cell_occupied),
    .grid_width(grid_width), .grid_height(grid_height),
    .neighbor_limit(neighbor_limit), .stat(stat),
    .total_removed(total_removed), .first_round_removed(first_round_removed),
    .round_count(round_count)
  );

endmodule
`default_nettype wire

### src/gnpc_checker.sv
`default_nettype none
module gnpc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        last_cell,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] total_removed,
  input wire logic [16:0] first_round_removed,
  input wire logic [16:0] round_count
);
  // A request is never taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // The last cell ends the load: no input is taken in the next cycle.
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_cell) |=> !in_ready) else $error("load continued");

  // Zero rounds means nothing was removed.
  a_zero_rounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && round_count == 17'd0) |-> (total_removed == 17'd0))
    else $error("removals without rounds");

  // First round cannot exceed total.
  a_first_le: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (first_round_removed <= total_removed)) else $error("first above total");

  // A held result keeps its total_removed value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(total_removed)) else $error("result changed");
endmodule

bind grid_neighbor_peeling_counter gnpc_checker u_gnpc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .last_cell(last_cell), .out_valid(out_valid), .out_ready(out_ready),
  .total_removed(total_removed), .first_round_removed(first_round_removed),
  .round_count(round_count)
);
`default_nettype wire
